[design/svag_pkg.sv]
package svag_pkg;

  // Widths of the item fields and configuration registers.
  localparam int unsigned IDX_W    = 32;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned STRIDE_W = 32;
  localparam int unsigned ADDR_W   = 50;
  localparam int unsigned LIMIT_W  = 33;
  localparam int unsigned CFG_W    = 33;
  localparam int unsigned CFG_IDX_W = 3;

  // Number of dimensions held in the register file, and the default rank.
  localparam int unsigned DIM_COUNT = 3;
  localparam int unsigned DEF_MAX_RANK = 3;

  // One divider cell per quotient bit, then one multiply-accumulate cell.
  localparam int unsigned CELLS_PER_DIM = IDX_W + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INNER_SIZE    = 3'd0,
    REG_MIDDLE_SIZE   = 3'd1,
    REG_OUTER_SIZE    = 3'd2,
    REG_INNER_STRIDE  = 3'd3,
    REG_MIDDLE_STRIDE = 3'd4,
    REG_OUTER_STRIDE  = 3'd5,
    REG_BASE_OFFSET   = 3'd6,
    REG_STORAGE_LIMIT = 3'd7
  } reg_index_t;

  // Data handed from cell to cell along the chain.
  typedef struct packed {
    logic [SIZE_W-1:0] rem;
    logic [IDX_W-1:0]  quo;
    logic [ADDR_W-1:0] addr;
  } stage_t;

endpackage

[design/svag_div_cell.sv]
module svag_div_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [svag_pkg::SIZE_W-1:0]       divisor,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  svag_pkg::stage_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output svag_pkg::stage_t                  out_data
);

  logic [svag_pkg::SIZE_W:0] trial;
  logic [svag_pkg::SIZE_W:0] diff;
  logic                      fits;
  svag_pkg::stage_t          step_next;

  // One restoring division step: bring in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {in_data.rem, in_data.quo[svag_pkg::IDX_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
    step_next.rem  = fits ? diff[svag_pkg::SIZE_W-1:0] : trial[svag_pkg::SIZE_W-1:0];
    step_next.quo  = {in_data.quo[svag_pkg::IDX_W-2:0], fits};
    step_next.addr = in_data.addr;
  end

  assign in_ready = !out_valid || out_ready;

  // The cell holds one item and passes it on whenever its neighbour can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= step_next;
    end
  end

endmodule

[design/svag_mac_cell.sv]
module svag_mac_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [svag_pkg::STRIDE_W-1:0]     stride,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  svag_pkg::stage_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output svag_pkg::stage_t                  out_data
);

  localparam int unsigned PROD_W = svag_pkg::SIZE_W + svag_pkg::STRIDE_W;

  logic [PROD_W-1:0] prod;
  svag_pkg::stage_t  acc_next;

  // Weight the coordinate by the stride and add it in; the quotient moves outward
  // as the dividend of the next dimension.
  always_comb begin
    prod          = PROD_W'(in_data.rem) * PROD_W'(stride);
    acc_next.rem  = '0;
    acc_next.quo  = in_data.quo;
    acc_next.addr = in_data.addr + svag_pkg::ADDR_W'(prod);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= acc_next;
    end
  end

endmodule

[design/strided_view_address_generator.sv]
// Channel      | Handshake             | Payload
// -------------+-----------------------+----------------------------------
// input item   | in_valid / in_ready   | flat_index
// result item  | out_valid / out_ready | storage_address, out_of_range
// config write | write_enable          | write_index, write_data
//
// One item enters per cycle unless stalled; each passes every cell in turn.
// Each dimension is 32 divider cells (one quotient bit each) and one multiply-add cell.
// Reset clears every valid bit and loads the register reset values.
// A stall at the output backs up cell by cell, so empty cells keep filling.
module strided_view_address_generator #(
  parameter int unsigned MAX_RANK = svag_pkg::DEF_MAX_RANK
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [svag_pkg::CFG_IDX_W-1:0]     write_index,
  input  logic [svag_pkg::CFG_W-1:0]         write_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [svag_pkg::IDX_W-1:0]         flat_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [svag_pkg::ADDR_W-1:0]        storage_address,
  output logic                               out_of_range
);

  localparam int unsigned PER_DIM = svag_pkg::CELLS_PER_DIM;
  localparam int unsigned NCELLS  = MAX_RANK * PER_DIM;

  logic [svag_pkg::SIZE_W-1:0]   dim_size   [svag_pkg::DIM_COUNT];
  logic [svag_pkg::STRIDE_W-1:0] dim_stride [svag_pkg::DIM_COUNT];
  logic [svag_pkg::STRIDE_W-1:0] base_offset;
  logic [svag_pkg::LIMIT_W-1:0]  storage_limit;
  logic [svag_pkg::SIZE_W-1:0]   divisor    [svag_pkg::DIM_COUNT];

  logic             chain_valid [NCELLS+1];
  logic             chain_ready [NCELLS+1];
  svag_pkg::stage_t chain_data  [NCELLS+1];

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_size[0]   <= svag_pkg::SIZE_W'(1);
      dim_size[1]   <= svag_pkg::SIZE_W'(1);
      dim_size[2]   <= svag_pkg::SIZE_W'(1);
      dim_stride[0] <= svag_pkg::STRIDE_W'(1);
      dim_stride[1] <= '0;
      dim_stride[2] <= '0;
      base_offset   <= '0;
      storage_limit <= '0;
    end else if (write_enable) begin
      case (svag_pkg::reg_index_t'(write_index))
        svag_pkg::REG_INNER_SIZE:    dim_size[0]   <= write_data[svag_pkg::SIZE_W-1:0];
        svag_pkg::REG_MIDDLE_SIZE:   dim_size[1]   <= write_data[svag_pkg::SIZE_W-1:0];
        svag_pkg::REG_OUTER_SIZE:    dim_size[2]   <= write_data[svag_pkg::SIZE_W-1:0];
        svag_pkg::REG_INNER_STRIDE:  dim_stride[0] <= write_data[svag_pkg::STRIDE_W-1:0];
        svag_pkg::REG_MIDDLE_STRIDE: dim_stride[1] <= write_data[svag_pkg::STRIDE_W-1:0];
        svag_pkg::REG_OUTER_STRIDE:  dim_stride[2] <= write_data[svag_pkg::STRIDE_W-1:0];
        svag_pkg::REG_BASE_OFFSET:   base_offset   <= write_data[svag_pkg::STRIDE_W-1:0];
        svag_pkg::REG_STORAGE_LIMIT: storage_limit <= write_data[svag_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero behaves as a size of one.
  always_comb begin
    for (int d = 0; d < svag_pkg::DIM_COUNT; d++) begin
      divisor[d] = (dim_size[d] == '0) ? svag_pkg::SIZE_W'(1) : dim_size[d];
    end
  end

  // Head of the chain: the index is the first dividend, the address starts at the base.
  assign chain_valid[0]     = in_valid;
  assign in_ready           = chain_ready[0];
  assign chain_data[0].rem  = '0;
  assign chain_data[0].quo  = flat_index;
  assign chain_data[0].addr = svag_pkg::ADDR_W'(base_offset);

  // Row of cells, one dimension after another, innermost first.
  for (genvar d = 0; d < MAX_RANK; d++) begin : g_dim
    for (genvar k = 0; k < svag_pkg::IDX_W; k++) begin : g_div
      svag_div_cell u_div (
        .clk       (clk),
        .rst       (rst),
        .divisor   (divisor[d]),
        .in_valid  (chain_valid[d*PER_DIM+k]),
        .in_ready  (chain_ready[d*PER_DIM+k]),
        .in_data   (chain_data[d*PER_DIM+k]),
        .out_valid (chain_valid[d*PER_DIM+k+1]),
        .out_ready (chain_ready[d*PER_DIM+k+1]),
        .out_data  (chain_data[d*PER_DIM+k+1])
      );
    end
    svag_mac_cell u_mac (
      .clk       (clk),
      .rst       (rst),
      .stride    (dim_stride[d]),
      .in_valid  (chain_valid[d*PER_DIM+PER_DIM-1]),
      .in_ready  (chain_ready[d*PER_DIM+PER_DIM-1]),
      .in_data   (chain_data[d*PER_DIM+PER_DIM-1]),
      .out_valid (chain_valid[d*PER_DIM+PER_DIM]),
      .out_ready (chain_ready[d*PER_DIM+PER_DIM]),
      .out_data  (chain_data[d*PER_DIM+PER_DIM])
    );
  end

  // Output register with the range check against the storage limit.
  assign chain_ready[NCELLS] = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chain_ready[NCELLS]) begin
      out_valid <= chain_valid[NCELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[NCELLS] && chain_valid[NCELLS]) begin
      storage_address <= chain_data[NCELLS].addr;
      out_of_range    <= (chain_data[NCELLS].addr >= svag_pkg::ADDR_W'(storage_limit));
    end
  end

endmodule

[tb/tb_top.sv]
module tb_top;

  localparam int unsigned LATENCY = svag_pkg::DEF_MAX_RANK * svag_pkg::CELLS_PER_DIM + 1;

  logic clk;
  logic rst;
  logic write_enable;
  logic [svag_pkg::CFG_IDX_W-1:0] write_index;
  logic [svag_pkg::CFG_W-1:0] write_data;
  logic in_valid;
  logic in_ready;
  logic [svag_pkg::IDX_W-1:0] flat_index;
  logic out_valid;
  logic out_ready;
  logic [svag_pkg::ADDR_W-1:0] storage_address;
  logic out_of_range;

  typedef struct {
    logic [svag_pkg::ADDR_W-1:0] addr;
    logic                        oor;
  } addr_result_t;

  // Shadow copy of the register file.
  logic [svag_pkg::SIZE_W-1:0]   shadow_size [svag_pkg::DIM_COUNT];
  logic [svag_pkg::STRIDE_W-1:0] shadow_stride [svag_pkg::DIM_COUNT];
  logic [31:0]                   shadow_base;
  logic [svag_pkg::LIMIT_W-1:0]  shadow_limit;

  logic [svag_pkg::IDX_W-1:0] index_queue [$];
  addr_result_t     addr_expected [$];
  int error_count = 0;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_recv;
  bit hold_start;
  bit in_fire;

  strided_view_address_generator u_top (
    .clk(clk), .rst(rst), .write_enable(write_enable), .write_index(write_index),
    .write_data(write_data), .in_valid(in_valid), .in_ready(in_ready),
    .flat_index(flat_index), .out_valid(out_valid), .out_ready(out_ready),
    .storage_address(storage_address), .out_of_range(out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Compute the storage address of one flat index from the shadow registers.
  function automatic addr_result_t predict_address(logic [svag_pkg::IDX_W-1:0] idx);
    addr_result_t r;
    logic [svag_pkg::IDX_W-1:0] rest;
    logic [svag_pkg::IDX_W-1:0] sz;
    logic [svag_pkg::IDX_W-1:0] coord;
    logic [svag_pkg::ADDR_W-1:0] sum;
    rest = idx;
    sum = svag_pkg::ADDR_W'(shadow_base);
    for (int d = 0; d < svag_pkg::DEF_MAX_RANK; d++) begin
      sz = (shadow_size[d] == 0) ? svag_pkg::IDX_W'(1) : svag_pkg::IDX_W'(shadow_size[d]);
      coord = rest % sz;
      rest = rest / sz;
      sum = sum + svag_pkg::ADDR_W'(coord) * svag_pkg::ADDR_W'(shadow_stride[d]);
    end
    r.addr = sum;
    r.oor = ({1'b0, sum} >= {18'd0, shadow_limit});
    return r;
  endfunction

  // Note whether an item was taken at the last rising edge.
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
    end
  end

  // Driver: offer the oldest pending item, idling at random between items.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      flat_index <= '0;
    end else if (in_valid && !in_fire) begin
      // hold the item until accepted
    end else if (index_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      flat_index <= index_queue.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver readiness.
  always @(negedge clk) begin
    out_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here while the sender carries on.
  initial begin
    hold_recv = 1'b0;
    wait (hold_start);
    hold_recv = 1'b1;
    repeat (LATENCY * 3) @(posedge clk);
    hold_recv = 1'b0;
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin
    addr_result_t e;
    if (!rst) begin
      if (in_valid && in_ready) addr_expected.push_back(predict_address(flat_index));
      if (out_valid && out_ready) begin
        if (addr_expected.size() == 0) begin
          $error("result item with no expectation: storage_address %0h", storage_address);
          error_count++;
        end else begin
          e = addr_expected.pop_front();
          if (storage_address !== e.addr) begin
            $error("storage_address expected %0h actual %0h", e.addr, storage_address);
            error_count++;
          end
          if (out_of_range !== e.oor) begin
            $error("out_of_range expected %0b actual %0b", e.oor, out_of_range);
            error_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(svag_pkg::reg_index_t idx, logic [svag_pkg::CFG_W-1:0] val);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(negedge clk);
    write_enable <= 1'b0;
    case (idx)
      svag_pkg::REG_INNER_SIZE:    shadow_size[0] = val[svag_pkg::SIZE_W-1:0];
      svag_pkg::REG_MIDDLE_SIZE:   shadow_size[1] = val[svag_pkg::SIZE_W-1:0];
      svag_pkg::REG_OUTER_SIZE:    shadow_size[2] = val[svag_pkg::SIZE_W-1:0];
      svag_pkg::REG_INNER_STRIDE:  shadow_stride[0] = val[svag_pkg::STRIDE_W-1:0];
      svag_pkg::REG_MIDDLE_STRIDE: shadow_stride[1] = val[svag_pkg::STRIDE_W-1:0];
      svag_pkg::REG_OUTER_STRIDE:  shadow_stride[2] = val[svag_pkg::STRIDE_W-1:0];
      svag_pkg::REG_BASE_OFFSET:   shadow_base = val[31:0];
      svag_pkg::REG_STORAGE_LIMIT: shadow_limit = val[svag_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until the queue has drained and every expected result has come.
  task automatic drain();
    while (index_queue.size() > 0 || in_valid || addr_expected.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Program one view; small sizes are favoured so that wrapping is common.
  task automatic random_view(bit extreme);
    logic [svag_pkg::CFG_W-1:0] lim;
    for (int d = 0; d < svag_pkg::DIM_COUNT; d++) begin
      write_reg(svag_pkg::reg_index_t'(d),
                extreme ? svag_pkg::CFG_W'($urandom_range(1) ? 16'hFFFF : 16'h0)
                : svag_pkg::CFG_W'($urandom_range(3) == 0 ? $urandom : $urandom_range(40)));
      write_reg(svag_pkg::reg_index_t'(svag_pkg::REG_INNER_STRIDE + d),
                extreme ? svag_pkg::CFG_W'(32'hFFFF_FFFF) : svag_pkg::CFG_W'($urandom));
    end
    write_reg(svag_pkg::REG_BASE_OFFSET,
              extreme ? svag_pkg::CFG_W'(32'hFFFF_FFFF) : svag_pkg::CFG_W'($urandom));
    lim = {1'($urandom_range(1)), 32'($urandom)};
    write_reg(svag_pkg::REG_STORAGE_LIMIT, $urandom_range(3) == 0 ? {1'b1, 32'h0} : lim);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: index_queue.push_back($urandom_range(64));
        1: index_queue.push_back($urandom_range(1) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE);
        default: index_queue.push_back($urandom);
      endcase
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_start = 1'b0;
    rst = 1'b1;
    write_enable = 1'b0;
    write_index = '0;
    write_data = '0;
    shadow_size = '{16'd1, 16'd1, 16'd1};
    shadow_stride = '{32'd1, 32'd0, 32'd0};
    shadow_base = '0;
    shadow_limit = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset view, then the extremes, zero sizes and wrapping.
    index_queue.push_back(32'd0);
    index_queue.push_back(32'hFFFF_FFFF);
    drain();
    write_reg(svag_pkg::REG_INNER_SIZE, 33'd3);
    write_reg(svag_pkg::REG_MIDDLE_SIZE, 33'd0);
    write_reg(svag_pkg::REG_OUTER_SIZE, 33'd5);
    write_reg(svag_pkg::REG_INNER_STRIDE, 33'd7);
    write_reg(svag_pkg::REG_MIDDLE_STRIDE, 33'd100);
    write_reg(svag_pkg::REG_OUTER_STRIDE, 33'd1000);
    write_reg(svag_pkg::REG_BASE_OFFSET, 33'd10);
    write_reg(svag_pkg::REG_STORAGE_LIMIT, 33'd3000);
    for (int i = 0; i < 16; i++) index_queue.push_back(i);
    index_queue.push_back(32'hFFFF_FFFF);
    drain();
    random_view(1'b1);
    index_queue.push_back(32'hFFFF_FFFF);
    index_queue.push_back(32'h0);
    index_queue.push_back(32'h5555_AAAA);
    index_queue.push_back(32'hAAAA_5555);
    drain();
    write_reg(svag_pkg::REG_STORAGE_LIMIT, {1'b1, 32'h0});
    write_reg(svag_pkg::REG_BASE_OFFSET, 33'd0);
    index_queue.push_back(32'hFFFF_FFFF);
    index_queue.push_back(32'd1);
    drain();

    // Random phases under each idling profile.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      random_view(ph == 5);
      if (ph == 2) begin
        // Long receiver hold-off so that the pipeline fills and backs up.
        hold_start = 1'b1;
        push_random(LATENCY + 60);
      end else begin
        push_random(100);
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[strided_view_address_generator.f]
design/svag_pkg.sv
design/svag_div_cell.sv
design/svag_mac_cell.sv
design/strided_view_address_generator.sv
tb/tb_top.sv
